// ===== sv/box_non_max_suppression_macros.svh =====
// Assertion helpers used by the top-level RTL file
`ifndef BOX_NON_MAX_SUPPRESSION_MACROS_SVH
`define BOX_NON_MAX_SUPPRESSION_MACROS_SVH

// same-cycle implication, checked out of reset
`define BNMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bnms: same-cycle check failed");

// next-cycle implication, checked out of reset
`define BNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bnms: next-cycle check failed");

`endif

// ===== sv/bnms_pkg.sv =====
package bnms_pkg;

  localparam int BOX_CAPACITY_DEF = 512;
  localparam int KEEP_LIMIT_DEF   = 32;

  localparam int COORD_W = 12;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 8;
  localparam int THR_W   = 16;

  localparam logic [THR_W-1:0] THR_RESET  = 16'd29491;
  localparam logic             MODE_RESET = 1'b0;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd1;
  localparam int CFG_DATA_W = 16;

  // overlap modes
  localparam logic MODE_IOU  = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // controller -> datapath commands
  typedef struct packed {
    logic box_we_in;     // store incoming item at addr
    logic box_we_best;   // write best of scan at addr
    logic box_we_first;  // write first of scan at best index
    logic scan;          // read addr as part of a max scan
    logic scan_first;    // this read opens the scan
    logic mark_clr;      // clear removal mark at addr
    logic keep_load;     // latch read box as keeper
    logic pipe_issue;    // read addr into the overlap pipe
    logic pend_load;     // keeper becomes pending result
    logic out_push;      // pending result into output register
    logic out_final;     // pushed result ends the set
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic removed;       // mark read at addr last cycle
    logic pipe_busy;     // overlap pipe still has work
    logic out_free;      // output register can take a result
    logic pend_valid;    // a kept box waits to be emitted
  } status_t;

endpackage

// ===== sv/bnms_ram.sv =====
module bnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bnms_ovl.sv =====
module bnms_ovl #(
  parameter int AW = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  logic [AW-1:0]               in_idx,
  input  bnms_pkg::box_t              kp,
  input  bnms_pkg::box_t              cd,
  input  logic [bnms_pkg::THR_W-1:0]  thr,
  input  logic                        mode,
  output logic                        out_v,
  output logic [AW-1:0]               out_idx,
  output logic                        hit,
  output logic                        busy
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] v_r;
  logic [AW-1:0]     idx_r [STAGES];

  // stage 1: edges, widths, center differences
  logic [11:0] min_r, max_l, min_b, max_t, max_r, min_l, max_b, min_t;
  logic signed [13:0] ix1_r, iy1_r, cw1_r, ch1_r, wa1_r, ha1_r, wb1_r, hb1_r;
  logic signed [14:0] dx1_r, dy1_r;
  logic [12:0] ksx, ksy, csx, csy;

  always_comb begin
    min_r = (kp.right  < cd.right)  ? kp.right  : cd.right;
    max_l = (kp.left   > cd.left)   ? kp.left   : cd.left;
    min_b = (kp.bottom < cd.bottom) ? kp.bottom : cd.bottom;
    max_t = (kp.top    > cd.top)    ? kp.top    : cd.top;
    max_r = (kp.right  > cd.right)  ? kp.right  : cd.right;
    min_l = (kp.left   < cd.left)   ? kp.left   : cd.left;
    max_b = (kp.bottom > cd.bottom) ? kp.bottom : cd.bottom;
    min_t = (kp.top    < cd.top)    ? kp.top    : cd.top;
    ksx   = {1'b0, kp.left} + {1'b0, kp.right};
    ksy   = {1'b0, kp.top}  + {1'b0, kp.bottom};
    csx   = {1'b0, cd.left} + {1'b0, cd.right};
    csy   = {1'b0, cd.top}  + {1'b0, cd.bottom};
  end

  always_ff @(posedge clk) begin
    ix1_r <= $signed({2'b0, min_r}) - $signed({2'b0, max_l});
    iy1_r <= $signed({2'b0, min_b}) - $signed({2'b0, max_t});
    cw1_r <= $signed({2'b0, max_r}) - $signed({2'b0, min_l});
    ch1_r <= $signed({2'b0, max_b}) - $signed({2'b0, min_t});
    wa1_r <= $signed({2'b0, kp.right})  - $signed({2'b0, kp.left});
    ha1_r <= $signed({2'b0, kp.bottom}) - $signed({2'b0, kp.top});
    wb1_r <= $signed({2'b0, cd.right})  - $signed({2'b0, cd.left});
    hb1_r <= $signed({2'b0, cd.bottom}) - $signed({2'b0, cd.top});
    dx1_r <= $signed({2'b0, ksx}) - $signed({2'b0, csx});
    dy1_r <= $signed({2'b0, ksy}) - $signed({2'b0, csy});
  end

  // stage 2: areas and squares; areas only matter when both boxes overlap
  logic        ovl2_r;
  logic [23:0] inter2_r, aa2_r, ab2_r, cwsq2_r, chsq2_r;
  logic [26:0] dxsq2_r, dysq2_r;
  logic signed [27:0] cwsq_f, chsq_f;
  logic signed [29:0] dxsq_f, dysq_f;

  always_comb begin
    cwsq_f = cw1_r * cw1_r;
    chsq_f = ch1_r * ch1_r;
    dxsq_f = dx1_r * dx1_r;
    dysq_f = dy1_r * dy1_r;
  end

  always_ff @(posedge clk) begin
    ovl2_r   <= (ix1_r > 14'sd0) && (iy1_r > 14'sd0);
    inter2_r <= ix1_r[11:0] * iy1_r[11:0];
    aa2_r    <= wa1_r[11:0] * ha1_r[11:0];
    ab2_r    <= wb1_r[11:0] * hb1_r[11:0];
    cwsq2_r  <= cwsq_f[23:0];
    chsq2_r  <= chsq_f[23:0];
    dxsq2_r  <= dxsq_f[26:0];
    dysq2_r  <= dysq_f[26:0];
  end

  // stage 3: union, enclosing diagonal, center distance
  logic [23:0] inter3_r;
  logic [24:0] uni3_r, c3_r;
  logic [27:0] d3_r;

  always_ff @(posedge clk) begin
    inter3_r <= ovl2_r ? inter2_r : 24'd0;
    uni3_r   <= ovl2_r ? ({1'b0, aa2_r} + {1'b0, ab2_r} - {1'b0, inter2_r}) : 25'd1;
    c3_r     <= {1'b0, cwsq2_r} + {1'b0, chsq2_r};
    d3_r     <= {1'b0, dxsq2_r} + {1'b0, dysq2_r};
  end

  // stage 4: cross products
  logic [48:0] m1_r;
  logic [52:0] m2_r;
  logic [49:0] m3_r;
  logic [40:0] m4_r;
  logic [23:0] inter4_r;
  logic        czero4_r;

  always_ff @(posedge clk) begin
    m1_r     <= inter3_r * c3_r;
    m2_r     <= d3_r * uni3_r;
    m3_r     <= uni3_r * c3_r;
    m4_r     <= thr * uni3_r;
    inter4_r <= inter3_r;
    czero4_r <= (c3_r == 25'd0);
  end

  // stage 5: distance-penalized numerator and plain overlap test
  logic signed [54:0] x5_r;
  logic [51:0] p5_r;
  logic        iou5_r, czero5_r;

  always_ff @(posedge clk) begin
    x5_r     <= $signed({4'b0, m1_r, 2'b0}) - $signed({2'b0, m2_r});
    p5_r     <= {m3_r, 2'b0};
    iou5_r   <= {1'b0, inter4_r, 16'b0} > m4_r;
    czero5_r <= czero4_r;
  end

  // stage 6: scale 4UC by the threshold, split in two partial products
  logic signed [54:0] x6_r;
  logic [51:0] qa6_r;
  logic [15:0] qb6_r;
  logic [31:0] qb_f;
  logic        iou6_r, czero6_r;

  assign qb_f = p5_r[15:0] * thr;

  always_ff @(posedge clk) begin
    x6_r     <= x5_r;
    qa6_r    <= p5_r[51:16] * thr;
    qb6_r    <= qb_f[31:16];
    iou6_r   <= iou5_r;
    czero6_r <= czero5_r;
  end

  // final compare
  logic [52:0] q6;
  assign q6  = {1'b0, qa6_r} + {37'b0, qb6_r};
  assign hit = ((mode == bnms_pkg::MODE_IOU) || czero6_r) ? iou6_r
             : ($signed({x6_r[54], x6_r}) > $signed({3'b0, q6}));

  // valid and index travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= in_idx;
    for (int s = 1; s < STAGES; s++) begin
      idx_r[s] <= idx_r[s-1];
    end
  end

  assign out_v   = v_r[STAGES-1];
  assign out_idx = idx_r[STAGES-1];
  assign busy    = |v_r;

endmodule

// ===== sv/bnms_dp.sv =====
module bnms_dp #(
  parameter int BOX_CAPACITY = bnms_pkg::BOX_CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bnms_pkg::cmd_t                  cmd,
  input  logic [$clog2(BOX_CAPACITY)-1:0] addr,
  output bnms_pkg::status_t               status,
  input  bnms_pkg::box_t                  in_box,
  input  logic [bnms_pkg::THR_W-1:0]      thr,
  input  logic                            mode,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bnms_pkg::box_t                  out_box,
  output logic                            out_final
);

  localparam int AW = $clog2(BOX_CAPACITY);

  bnms_pkg::box_t box_rd, box_wdata;
  logic [AW-1:0]  box_waddr;
  logic           box_we;
  logic           mark_rd, mark_we, mark_wdata;
  logic [AW-1:0]  mark_waddr;

  // scan and pipe bookkeeping, delayed to line up with the registered read data
  logic           scan_d_r, scan_first_d_r, iss_d_r;
  logic [AW-1:0]  addr_d_r;
  bnms_pkg::box_t best_r, first_r, keeper_r, pend_r, out_box_r;
  logic [AW-1:0]  best_idx_r;
  logic           pend_valid_r, out_valid_r, out_final_r;

  logic           p_v, p_hit, p_busy;
  logic [AW-1:0]  p_idx;

  // box store write select
  always_comb begin
    box_we    = cmd.box_we_in | cmd.box_we_best | cmd.box_we_first;
    box_waddr = cmd.box_we_first ? best_idx_r : addr;
    box_wdata = in_box;
    if (cmd.box_we_best) begin
      box_wdata = best_r;
    end else if (cmd.box_we_first) begin
      box_wdata = first_r;
    end
  end

  bnms_ram #(.WIDTH(bnms_pkg::BOX_W), .DEPTH(BOX_CAPACITY)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_waddr),
    .wdata (box_wdata),
    .raddr (addr),
    .rdata (box_rd)
  );

  // removal marks: cleared by sweep, set by the overlap pipe
  always_comb begin
    mark_we    = cmd.mark_clr | (p_v & p_hit);
    mark_waddr = cmd.mark_clr ? addr : p_idx;
    mark_wdata = ~cmd.mark_clr;
  end

  bnms_ram #(.WIDTH(1), .DEPTH(BOX_CAPACITY)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (addr),
    .rdata (mark_rd)
  );

  bnms_ovl #(.AW(AW)) u_ovl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (iss_d_r),
    .in_idx  (addr_d_r),
    .kp      (keeper_r),
    .cd      (box_rd),
    .thr     (thr),
    .mode    (mode),
    .out_v   (p_v),
    .out_idx (p_idx),
    .hit     (p_hit),
    .busy    (p_busy)
  );

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_d_r     <= 1'b0;
      iss_d_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      scan_d_r <= cmd.scan;
      iss_d_r  <= cmd.pipe_issue;
      if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.out_push && cmd.out_final) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_first_d_r <= cmd.scan_first;
    addr_d_r       <= addr;
    // running maximum, first strictly greater wins
    if (scan_d_r) begin
      if (scan_first_d_r) begin
        best_r     <= box_rd;
        best_idx_r <= addr_d_r;
        first_r    <= box_rd;
      end else if (box_rd.score > best_r.score) begin
        best_r     <= box_rd;
        best_idx_r <= addr_d_r;
      end
    end
    if (cmd.keep_load) begin
      keeper_r <= box_rd;
    end
    if (cmd.pend_load) begin
      pend_r <= keeper_r;
    end
    if (cmd.out_push) begin
      out_box_r   <= pend_r;
      out_final_r <= cmd.out_final;
    end
  end

  assign status.removed    = mark_rd;
  assign status.pipe_busy  = iss_d_r | p_busy;
  assign status.out_free   = ~out_valid_r | out_ready;
  assign status.pend_valid = pend_valid_r;

  assign out_valid = out_valid_r;
  assign out_box   = out_box_r;
  assign out_final = out_final_r;

endmodule

// ===== sv/bnms_ctrl.sv =====
module bnms_ctrl #(
  parameter int BOX_CAPACITY = bnms_pkg::BOX_CAPACITY_DEF,
  parameter int KEEP_LIMIT   = bnms_pkg::KEEP_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_is_last,
  output logic                            in_ready,
  output bnms_pkg::cmd_t                  cmd,
  output logic [$clog2(BOX_CAPACITY)-1:0] addr,
  input  bnms_pkg::status_t               status
);

  localparam int AW = $clog2(BOX_CAPACITY);
  localparam int CW = $clog2(BOX_CAPACITY + 1);
  localparam int KW = $clog2(KEEP_LIMIT + 1);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_SORT_RD  = 4'd1;
  localparam logic [3:0] S_SORT_WT  = 4'd2;
  localparam logic [3:0] S_SORT_SW1 = 4'd3;
  localparam logic [3:0] S_SORT_SW2 = 4'd4;
  localparam logic [3:0] S_CLR      = 4'd5;
  localparam logic [3:0] S_SUP_RD   = 4'd6;
  localparam logic [3:0] S_SUP_CHK  = 4'd7;
  localparam logic [3:0] S_SUP_EMIT = 4'd8;
  localparam logic [3:0] S_SUP_SCAN = 4'd9;
  localparam logic [3:0] S_SUP_DRN  = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, cnt_sat;
  logic [KW-1:0] keep_r, keep_nxt;
  logic          cnt_room, j_last, i_last, sort_more, keep_full;

  always_comb begin
    cnt_room  = cnt_r < CW'(BOX_CAPACITY);
    cnt_sat   = cnt_room ? CW'(cnt_r + 1'b1) : cnt_r;
    j_last    = CW'(j_r + 1'b1) == cnt_r;
    i_last    = CW'(i_r + 1'b1) == cnt_r;
    sort_more = ({1'b0, i_r} + (CW+1)'(2)) < {1'b0, cnt_r};
    keep_full = KW'(keep_r + 1'b1) == KW'(KEEP_LIMIT);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    keep_nxt  = keep_r;
    cmd       = '0;
    in_ready  = 1'b0;
    addr      = i_r[AW-1:0];
    case (state_r)
      S_LOAD: begin
        in_ready      = 1'b1;
        addr          = cnt_r[AW-1:0];
        cmd.box_we_in = in_valid & cnt_room;
        if (in_valid) begin
          cnt_nxt = cnt_sat;
          if (in_is_last) begin
            i_nxt = '0;
            j_nxt = '0;
            state_nxt = (cnt_sat > CW'(1)) ? S_SORT_RD : S_CLR;
          end
        end
      end
      // scan i..n-1 for the highest score
      S_SORT_RD: begin
        addr           = j_r[AW-1:0];
        cmd.scan       = 1'b1;
        cmd.scan_first = (j_r == i_r);
        if (j_last) begin
          state_nxt = S_SORT_WT;
        end else begin
          j_nxt = CW'(j_r + 1'b1);
        end
      end
      S_SORT_WT: begin
        state_nxt = S_SORT_SW1;
      end
      S_SORT_SW1: begin
        cmd.box_we_best = 1'b1;
        state_nxt = S_SORT_SW2;
      end
      S_SORT_SW2: begin
        cmd.box_we_first = 1'b1;
        i_nxt = CW'(i_r + 1'b1);
        j_nxt = CW'(i_r + 1'b1);
        if (sort_more) begin
          state_nxt = S_SORT_RD;
        end else begin
          j_nxt = '0;
          state_nxt = S_CLR;
        end
      end
      // clear marks of the loaded entries
      S_CLR: begin
        addr         = j_r[AW-1:0];
        cmd.mark_clr = 1'b1;
        if (j_last) begin
          i_nxt = '0;
          keep_nxt = '0;
          state_nxt = S_SUP_RD;
        end else begin
          j_nxt = CW'(j_r + 1'b1);
        end
      end
      S_SUP_RD: begin
        state_nxt = S_SUP_CHK;
      end
      S_SUP_CHK: begin
        if (status.removed) begin
          if (i_last) begin
            state_nxt = S_FIN;
          end else begin
            i_nxt = CW'(i_r + 1'b1);
            state_nxt = S_SUP_RD;
          end
        end else begin
          cmd.keep_load = 1'b1;
          state_nxt = S_SUP_EMIT;
        end
      end
      // previous keeper goes out, this one becomes pending
      S_SUP_EMIT: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.out_push  = status.pend_valid;
          cmd.pend_load = 1'b1;
          keep_nxt = KW'(keep_r + 1'b1);
          if (keep_full || i_last) begin
            state_nxt = S_FIN;
          end else begin
            j_nxt = CW'(i_r + 1'b1);
            state_nxt = S_SUP_SCAN;
          end
        end
      end
      S_SUP_SCAN: begin
        addr           = j_r[AW-1:0];
        cmd.pipe_issue = 1'b1;
        if (j_last) begin
          state_nxt = S_SUP_DRN;
        end else begin
          j_nxt = CW'(j_r + 1'b1);
        end
      end
      S_SUP_DRN: begin
        if (!status.pipe_busy) begin
          i_nxt = CW'(i_r + 1'b1);
          state_nxt = S_SUP_RD;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_push  = 1'b1;
          cmd.out_final = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      keep_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      keep_r  <= keep_nxt;
    end
  end

endmodule

// ===== sv/box_non_max_suppression.sv =====
// Channel  | Signals                                    | Transfer
// ---------+--------------------------------------------+---------------------
// in       | in_valid/in_ready, box fields, in_is_last  | valid & ready
// out      | out_valid/out_ready, kept fields, final    | valid & ready
// cfg      | cfg_we, cfg_index, cfg_data                | cfg_we
//
// Loading takes one box per cycle. After the last box, a selection sort
// orders the boxes by descending score (one box store read per cycle);
// then the removal marks are cleared, and each kept box is compared with
// later boxes in the overlap pipeline. Reset is synchronous, active low.
// Input is not taken from the last box until the final result is loaded;
// a stalled output holds the controller before the next result.
`include "box_non_max_suppression_macros.svh"

module box_non_max_suppression #(
  parameter int BOX_CAPACITY = bnms_pkg::BOX_CAPACITY_DEF,
  parameter int KEEP_LIMIT   = bnms_pkg::KEEP_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bnms_pkg::COORD_W-1:0]        in_left,
  input  logic [bnms_pkg::COORD_W-1:0]        in_top,
  input  logic [bnms_pkg::COORD_W-1:0]        in_right,
  input  logic [bnms_pkg::COORD_W-1:0]        in_bottom,
  input  logic [bnms_pkg::SCORE_W-1:0]        in_confidence,
  input  logic [bnms_pkg::CLASS_W-1:0]        in_class_id,
  input  logic                                in_is_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bnms_pkg::COORD_W-1:0]        out_kept_left,
  output logic [bnms_pkg::COORD_W-1:0]        out_kept_top,
  output logic [bnms_pkg::COORD_W-1:0]        out_kept_right,
  output logic [bnms_pkg::COORD_W-1:0]        out_kept_bottom,
  output logic [bnms_pkg::SCORE_W-1:0]        out_kept_confidence,
  output logic [bnms_pkg::CLASS_W-1:0]        out_kept_class,
  output logic                                out_final_kept,
  input  logic                                cfg_we,
  input  logic [bnms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bnms_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(BOX_CAPACITY);

  logic [bnms_pkg::THR_W-1:0] thr_r;
  logic                       mode_r;
  bnms_pkg::cmd_t             cmd;
  bnms_pkg::status_t          status;
  logic [AW-1:0]              addr;
  bnms_pkg::box_t             in_box, out_box;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= bnms_pkg::THR_RESET;
      mode_r <= bnms_pkg::MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bnms_pkg::CFG_THRESHOLD: thr_r  <= cfg_data[bnms_pkg::THR_W-1:0];
        bnms_pkg::CFG_MODE:      mode_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_box.left   = in_left;
    in_box.top    = in_top;
    in_box.right  = in_right;
    in_box.bottom = in_bottom;
    in_box.score  = in_confidence;
    in_box.cls    = in_class_id;
  end

  bnms_ctrl #(.BOX_CAPACITY(BOX_CAPACITY), .KEEP_LIMIT(KEEP_LIMIT)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .addr       (addr),
    .status     (status)
  );

  bnms_dp #(.BOX_CAPACITY(BOX_CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .status    (status),
    .in_box    (in_box),
    .thr       (thr_r),
    .mode      (mode_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_box   (out_box),
    .out_final (out_final_kept)
  );

  assign out_kept_left       = out_box.left;
  assign out_kept_top        = out_box.top;
  assign out_kept_right      = out_box.right;
  assign out_kept_bottom     = out_box.bottom;
  assign out_kept_confidence = out_box.score;
  assign out_kept_class      = out_box.cls;

  // a result is only pushed when the output register can take it
  `BNMS_ASSERT_SAME(a_push_free, clk, rst_n, cmd.out_push, status.out_free)
  // no input transfer while results are being produced
  `BNMS_ASSERT_SAME(a_load_quiet, clk, rst_n, in_ready, !cmd.out_push && !status.pipe_busy)
  // sort swaps never overlap suppression traffic
  `BNMS_ASSERT_SAME(a_swap_quiet, clk, rst_n, cmd.box_we_best || cmd.box_we_first,
                    !status.pipe_busy && !cmd.mark_clr)
  // a final push leaves the block ready for the next set
  `BNMS_ASSERT_NEXT(a_final_load, clk, rst_n, cmd.out_push && cmd.out_final, in_ready)

endmodule
